// ===== src/mf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

	localparam int PIX_W         = 8;
	localparam int COL_W         = 10;
	localparam int ROW_W         = 12;
	localparam int IMG_W_W       = 11;
	localparam int IMG_H_W       = 13;
	localparam int CFG_W         = 13;
	localparam int WIN_N         = 9;
	localparam int WIN_MID       = 4;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WIN_N-1:0] win_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             vld;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} tag_t;

endpackage

// ===== src/median_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order stream of 8-bit green samples.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_ready is high and gives one word per interior
// pixel, tagged with the centre column and row; border pixels give none. A pixel is
// registered by the line buffer read, then by the window, then by each of the nine
// odd-even sort cells in the chain, whose last cell is the output register. The
// whole pipeline moves whenever the output register is empty or being taken,
// so in_ready follows out_ready while a result waits. A write to either size
// register restarts the frame at pixel (0,0); no clearing pass is needed.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
	parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [mf_pkg::PIX_W-1:0] green,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [mf_pkg::PIX_W-1:0] median,
	output logic [mf_pkg::COL_W-1:0] col,
	output logic [mf_pkg::ROW_W-1:0] row,
	input  logic                     cfg_we,
	input  mf_pkg::cfg_reg_t         cfg_index,
	input  logic [mf_pkg::CFG_W-1:0] cfg_data
);
	import mf_pkg::*;

	logic en;
	tag_t tag  [WIN_N+1];
	win_t vals [WIN_N+1];

	assign en       = ~tag[WIN_N].vld | out_ready;
	assign in_ready = en;

	mf_line_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.green    (green),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.win_tag  (tag[0]),
		.win      (vals[0])
	);

	for (genvar i = 0; i < WIN_N; i++) begin : g_sort
		mf_sort_cell #(
			.PHASE(1'(i % 2))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tag_in  (tag[i]),
			.vals_in (vals[i]),
			.tag_out (tag[i+1]),
			.vals_out(vals[i+1])
		);
	end

	assign out_valid = tag[WIN_N].vld;
	assign median    = vals[WIN_N][WIN_MID];
	assign col       = tag[WIN_N].col;
	assign row       = tag[WIN_N].row;

endmodule

// ===== src/mf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/mf_sort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_sort_cell
// One odd-even transposition step over the nine window samples, registered.
// ----------------------------------------------------------------------------
module mf_sort_cell #(
	parameter bit PHASE = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  mf_pkg::tag_t  tag_in,
	input  mf_pkg::win_t  vals_in,
	output mf_pkg::tag_t  tag_out,
	output mf_pkg::win_t  vals_out
);
	import mf_pkg::*;

	win_t             nxt;
	logic             vld_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	win_t             vals_q;

	always_comb begin
		nxt = vals_in;
		for (int i = int'(PHASE); i < WIN_N - 1; i += 2) begin
			if (vals_in[i] > vals_in[i+1]) begin
				nxt[i]   = vals_in[i+1];
				nxt[i+1] = vals_in[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= tag_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_q  <= tag_in.col;
			row_q  <= tag_in.row;
			vals_q <= nxt;
		end
	end

	assign tag_out  = '{vld: vld_q, col: col_q, row: row_q};
	assign vals_out = vals_q;

endmodule

// ===== src/mf_line_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_line_window
// Frame counters, size registers, line buffers and the 3x3 window.
// ----------------------------------------------------------------------------
module mf_line_window #(
	parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [mf_pkg::PIX_W-1:0]    green,
	input  logic                        cfg_we,
	input  mf_pkg::cfg_reg_t            cfg_index,
	input  logic [mf_pkg::CFG_W-1:0]    cfg_data,
	output mf_pkg::tag_t                win_tag,
	output mf_pkg::win_t                win
);
	import mf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CW-1:0]      last_col;
	logic [ROW_W-1:0]   last_row;
	logic               accept;
	logic               interior;

	logic               vld_s1;
	logic               interior_s1;
	pix_t               green_s1;
	logic [CW-1:0]      col_s1;
	logic [COL_W-1:0]   ocol_s1;
	logic [ROW_W-1:0]   orow_s1;

	logic [2*PIX_W-1:0] rd_data;
	pix_t               up1;
	pix_t               up2;

	logic               vld_s2;
	logic [COL_W-1:0]   col_s2;
	logic [ROW_W-1:0]   row_s2;
	win_t               win_q;

	assign accept   = in_valid & en;
	assign interior = (col_q >= CW'(2)) && (row_q >= ROW_W'(2));

	always_comb begin
		if (int'(image_width_q) < MIN_DIM) begin
			last_col = CW'(MIN_DIM - 1);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(int'(image_width_q) - 1);
		end
		if (int'(image_height_q) < MIN_DIM) begin
			last_row = ROW_W'(MIN_DIM - 1);
		end else if (int'(image_height_q) > MAX_HEIGHT) begin
			last_row = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			last_row = ROW_W'(int'(image_height_q) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_W'(WIDTH_RST);
			image_height_q <= IMG_H_W'(HEIGHT_RST);
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[IMG_W_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[IMG_H_W-1:0];
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line buffer word: upper byte two rows up, lower byte one row up
	mf_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (en & vld_s1),
		.waddr(col_s1),
		.wdata({up1, green_s1}),
		.re   (en),
		.raddr(col_q),
		.rdata(rd_data)
	);

	assign up1 = rd_data[PIX_W-1:0];
	assign up2 = rd_data[2*PIX_W-1:PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1 & interior_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			green_s1    <= green;
			col_s1      <= col_q;
			interior_s1 <= interior;
			ocol_s1     <= COL_W'(int'(col_q) - 1);
			orow_s1     <= ROW_W'(int'(row_q) - 1);
			col_s2      <= ocol_s1;
			row_s2      <= orow_s1;
			if (vld_s1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= up2;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= up1;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= green_s1;
			end
		end
	end

	assign win_tag = '{vld: vld_s2, col: col_s2, row: row_s2};
	assign win     = win_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the 3x3 median filter.
// ----------------------------------------------------------------------------
// Streams pixel words in raster order and predicts every median word, with
// its centre column and row, from a behavioral copy of the line buffers,
// window and counters. Results are checked in order as they are taken. The
// sender and the receiver idle and stall at random. Frame sizes are rewritten
// between phases, clamped sizes and a restart in mid frame included.
// ----------------------------------------------------------------------------
module tb_top;
	import mf_pkg::*;

	typedef struct packed {
		pix_t             median;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} median_word_t;

	class median_tracker;
		int unsigned  width_reg;
		int unsigned  height_reg;
		int unsigned  col_cnt;
		int unsigned  row_cnt;
		pix_t         above[MAX_WIDTH_DEF];
		pix_t         two_above[MAX_WIDTH_DEF];
		pix_t         win[WIN_N];
		median_word_t medians_due[$];
		int           errors;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			col_cnt    = 0;
			row_cnt    = 0;
			errors     = 0;
			foreach (above[i]) begin
				above[i]     = '0;
				two_above[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		// rank select: the sample with at most four below it and at least five at or below it
		function pix_t window_median();
			int lt;
			int le;
			for (int i = 0; i < WIN_N; i++) begin
				lt = 0;
				le = 0;
				for (int j = 0; j < WIN_N; j++) begin
					if (win[j] < win[i]) lt++;
					if (win[j] <= win[i]) le++;
				end
				if (lt <= WIN_MID && le > WIN_MID) return win[i];
			end
			return win[WIN_MID];
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
			if (idx == REG_IMAGE_WIDTH) begin
				width_reg = d[IMG_W_W-1:0];
			end else begin
				height_reg = d[IMG_H_W-1:0];
			end
			col_cnt = 0;
			row_cnt = 0;
		endfunction

		function void take_pixel(pix_t g);
			int unsigned  c;
			int unsigned  r;
			pix_t         up1;
			pix_t         up2;
			median_word_t e;
			c   = col_cnt;
			r   = row_cnt;
			up1 = above[c];
			up2 = two_above[c];
			for (int k = 0; k < 3; k++) begin
				win[3*k]   = win[3*k+1];
				win[3*k+1] = win[3*k+2];
			end
			win[2]       = up2;
			win[5]       = up1;
			win[8]       = g;
			two_above[c] = up1;
			above[c]     = g;
			if (c >= 2 && r >= 2) begin
				e.median = window_median();
				e.col    = COL_W'(c - 1);
				e.row    = ROW_W'(r - 1);
				medians_due.push_back(e);
			end
			c++;
			if (c >= eff_width()) begin
				c = 0;
				r++;
				if (r >= eff_height()) r = 0;
			end
			col_cnt = c;
			row_cnt = r;
		endfunction

		function void check_median(pix_t m, logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
			median_word_t e;
			if (medians_due.size() == 0) begin
				$display("%0t: unexpected word median %0d col %0d row %0d", $time, m, c, r);
				errors++;
				return;
			end
			e = medians_due.pop_front();
			if (m !== e.median) begin
				$display("%0t: median expected %0d got %0d", $time, e.median, m);
				errors++;
			end
			if (c !== e.col) begin
				$display("%0t: col expected %0d got %0d", $time, e.col, c);
				errors++;
			end
			if (r !== e.row) begin
				$display("%0t: row expected %0d got %0d", $time, e.row, r);
				errors++;
			end
		endfunction

		function int pending();
			return medians_due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	pix_t             green;
	logic             out_valid;
	logic             out_ready;
	pix_t             median;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic             cfg_we;
	cfg_reg_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bit            send_quiet;
	bit            recv_quiet;
	median_tracker tracker = new();

	median_filter_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.green     (green),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.col       (col),
		.row       (row),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("median_filter_3x3 regression: fail");
		$finish;
	end

	function automatic pix_t pick_green(int style);
		if (style == 1) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'h01;
				2: return 8'h02;
				default: return 8'hFF;
			endcase
		end
		if (style == 2) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return pix_t'($urandom_range(0, 255));
	endfunction

	task automatic send_pixel(input pix_t g);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		green    <= g;
		do @(posedge clk); while (!in_ready);
		tracker.take_pixel(g);
		@(negedge clk);
	endtask

	task automatic drain(input int extra);
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
		drain(16);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		tracker.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = recv_quiet ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.check_median(median, col, row);
			@(negedge clk);
		end
	end

	initial begin
		pix_t             directed_px[29];
		int               rand_sent;
		int               n;
		int               pause_at;
		int               style;
		int               mode;
		int               pick;
		int unsigned      w;
		int unsigned      h;
		logic [1:0]       hi;
		logic [CFG_W-1:0] wd;
		bit               first;

		directed_px = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
			8'h80, 8'h7F, 8'h01, 8'hFE, 8'h80, 8'h80, 8'h7F, 8'h01, 8'hFE,
			8'h00, 8'h01, 8'hFF, 8'hFE, 8'h40, 8'h10, 8'h20, 8'h7F, 8'h80, 8'hFF, 8'h00};
		in_valid   = 1'b0;
		green      = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_IMAGE_WIDTH;
		cfg_data   = '0;
		arst_n     = 1'b0;
		send_quiet = 1'b1;
		recv_quiet = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset frame size, just into the first interior row
		for (int i = 0; i < 2 * WIDTH_RST + 10; i++) send_pixel(pick_green(0));

		// clamped 3x3 frames, two of them, then a partial 4-wide frame
		send_quiet = 1'b0;
		write_reg(REG_IMAGE_WIDTH, 13'h0000);
		write_reg(REG_IMAGE_HEIGHT, 13'h0001);
		for (int i = 0; i < 18; i++) send_pixel(directed_px[i]);
		write_reg(REG_IMAGE_WIDTH, 13'h1804);
		for (int i = 18; i < 29; i++) send_pixel(directed_px[i]);

		// widest row, restarting the previous frame mid way
		write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 13'h0000);
		send_quiet = 1'b1;
		n = 2 * MAX_WIDTH_DEF + $urandom_range(3, 60);
		for (int i = 0; i < n; i++) send_pixel(pick_green(0));

		rand_sent = 0;
		first     = 1'b1;
		while (rand_sent < 600) begin
			mode = first ? 0 : $urandom_range(0, 2);
			first = 1'b0;
			pick = $urandom_range(0, 9);
			if (pick < 2) w = $urandom_range(0, 2);
			else if (pick < 7) w = $urandom_range(3, 8);
			else w = $urandom_range(9, 40);
			pick = $urandom_range(0, 9);
			if (pick < 3) h = $urandom_range(0, 2);
			else if (pick < 8) h = $urandom_range(3, 6);
			else h = $urandom_range(4097, 8191);
			hi = 2'($urandom_range(0, 3));
			wd = {hi, IMG_W_W'(w)};
			if (mode == 0) begin
				if ($urandom_range(0, 1) != 0) begin
					write_reg(REG_IMAGE_WIDTH, wd);
					write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
				end else begin
					write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
					write_reg(REG_IMAGE_WIDTH, wd);
				end
			end else if (mode == 1) begin
				write_reg(REG_IMAGE_WIDTH, wd);
			end else begin
				write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
			end
			n = tracker.eff_width() * tracker.eff_height() * $urandom_range(1, 2)
				+ $urandom_range(0, 2 * tracker.eff_width());
			if (n > 200) n = 200;
			style      = $urandom_range(0, 2);
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			pause_at   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
			for (int i = 0; i < n; i++) begin
				if (i == pause_at) drain($urandom_range(1, 5));
				send_pixel(pick_green(style));
			end
			rand_sent += n;
		end

		drain(30);
		if (tracker.errors == 0) begin
			$display("median_filter_3x3 regression: pass");
		end else begin
			$display("median_filter_3x3 regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/mf_pkg.sv
src/mf_ram.sv
src/mf_sort_cell.sv
src/mf_line_window.sv
src/median_filter_3x3.sv
verif/tb_top.sv
